FILE: rtl/qcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcr_pkg
// Shared types, constants and the product schedule of the quaternion
// composition block.
// ----------------------------------------------------------------------------
package qcr_pkg;

    localparam int COMPONENT_WIDTH_DEF = 18;
    localparam int CFG_WIDTH           = 10;
    localparam logic [CFG_WIDTH-1:0] INTERVAL_RESET = 10'd100;
    localparam int NUM_COMP            = 4;
    localparam int COMPOSE_STEPS       = 16;

    localparam logic [1:0] SEL_X = 2'd0;
    localparam logic [1:0] SEL_Y = 2'd1;
    localparam logic [1:0] SEL_Z = 2'd2;
    localparam logic [1:0] SEL_W = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_MUL_DRAIN,
        ST_FINISH,
        ST_SQ,
        ST_SQ_DRAIN,
        ST_SQ_CHECK,
        ST_SQRT,
        ST_DIV_INIT,
        ST_DIV,
        ST_DIV_STORE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [1:0] a_sel;
        logic [1:0] b_sel;
        logic       neg;
    } t_mul_op;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic       mul_sq;
        logic [3:0] mul_step;
        logic       finish;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       div_init;
        logic       div_step;
        logic       div_store;
        logic [1:0] comp;
        logic       push;
    } t_cmd;

    typedef struct packed {
        logic sum_zero;
    } t_sts;

    // Four products per component; the step's upper two bits give the component.
    function automatic t_mul_op mul_op(input logic [3:0] step);
        t_mul_op op;
        op = '{a_sel: SEL_X, b_sel: SEL_X, neg: 1'b0};
        unique case (step)
            4'd0:  op = '{a_sel: SEL_X, b_sel: SEL_W, neg: 1'b0};
            4'd1:  op = '{a_sel: SEL_W, b_sel: SEL_X, neg: 1'b0};
            4'd2:  op = '{a_sel: SEL_Z, b_sel: SEL_Y, neg: 1'b0};
            4'd3:  op = '{a_sel: SEL_Y, b_sel: SEL_Z, neg: 1'b1};
            4'd4:  op = '{a_sel: SEL_Y, b_sel: SEL_W, neg: 1'b0};
            4'd5:  op = '{a_sel: SEL_W, b_sel: SEL_Y, neg: 1'b0};
            4'd6:  op = '{a_sel: SEL_X, b_sel: SEL_Z, neg: 1'b0};
            4'd7:  op = '{a_sel: SEL_Z, b_sel: SEL_X, neg: 1'b1};
            4'd8:  op = '{a_sel: SEL_Z, b_sel: SEL_W, neg: 1'b0};
            4'd9:  op = '{a_sel: SEL_W, b_sel: SEL_Z, neg: 1'b0};
            4'd10: op = '{a_sel: SEL_Y, b_sel: SEL_X, neg: 1'b0};
            4'd11: op = '{a_sel: SEL_X, b_sel: SEL_Y, neg: 1'b1};
            4'd12: op = '{a_sel: SEL_W, b_sel: SEL_W, neg: 1'b0};
            4'd13: op = '{a_sel: SEL_X, b_sel: SEL_X, neg: 1'b1};
            4'd14: op = '{a_sel: SEL_Y, b_sel: SEL_Y, neg: 1'b1};
            4'd15: op = '{a_sel: SEL_Z, b_sel: SEL_Z, neg: 1'b1};
        endcase
        return op;
    endfunction

endpackage

FILE: rtl/qcr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcr_datapath
// Shared multiplier with accumulators, rounding and saturation, a bit-serial
// square root and a bit-serial divider for normalisation.
// ----------------------------------------------------------------------------
module qcr_datapath #(
    parameter int W = qcr_pkg::COMPONENT_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic signed [W-1:0]  i_a_x,
    input  logic signed [W-1:0]  i_a_y,
    input  logic signed [W-1:0]  i_a_z,
    input  logic signed [W-1:0]  i_a_w,
    input  logic signed [W-1:0]  i_b_x,
    input  logic signed [W-1:0]  i_b_y,
    input  logic signed [W-1:0]  i_b_z,
    input  logic signed [W-1:0]  i_b_w,
    input  qcr_pkg::t_cmd        i_cmd,
    output qcr_pkg::t_sts        o_sts,
    output logic signed [W-1:0]  o_r_x,
    output logic signed [W-1:0]  o_r_y,
    output logic signed [W-1:0]  o_r_z,
    output logic signed [W-1:0]  o_r_w
);

    localparam int F  = W - 2;
    localparam int PW = 2 * W;
    localparam int AW = 2 * W + 2;
    localparam int SW = 2 * W + 2;
    localparam int RW = W + 1;
    localparam int QW = W + 4;
    localparam int NW = 2 * W - 2;
    localparam int DW = W + 2;
    localparam logic signed [AW-1:0] HALF    = AW'(64'sd1 <<< (F - 1));
    localparam logic signed [AW-1:0] SAT_MAX = AW'((64'sd1 <<< (W - 1)) - 64'sd1);
    localparam logic signed [AW-1:0] SAT_MIN = -SAT_MAX - AW'(1);

    logic signed [W-1:0]  r_a   [qcr_pkg::NUM_COMP];
    logic signed [W-1:0]  r_b   [qcr_pkg::NUM_COMP];
    logic signed [W-1:0]  r_res [qcr_pkg::NUM_COMP];
    logic signed [W-1:0]  r_out [qcr_pkg::NUM_COMP];
    logic signed [AW-1:0] r_acc [qcr_pkg::NUM_COMP];
    logic signed [W-1:0]  fin   [qcr_pkg::NUM_COMP];

    logic signed [PW-1:0] r_prod;
    logic                 r_pvalid;
    logic                 r_psq;
    logic                 r_pneg;
    logic [1:0]           r_pcomp;
    logic [SW-1:0]        r_sum;
    logic [SW-1:0]        r_sqs;
    logic [QW-1:0]        r_srem;
    logic [RW-1:0]        r_root;
    logic [NW-1:0]        r_num;
    logic [DW-1:0]        r_drem;
    logic                 r_dneg;

    qcr_pkg::t_mul_op     op;
    logic signed [W-1:0]  mul_a;
    logic signed [W-1:0]  mul_b;
    logic signed [PW-1:0] mul_p;
    logic signed [W-1:0]  sel_res;
    logic [W-1:0]         sel_mag;
    logic [QW-1:0]        srem_sh;
    logic [QW-1:0]        trial;
    logic [DW-1:0]        dsh;
    logic                 qbit;
    logic [W-1:0]         q_mag;

    always_comb begin
        op      = qcr_pkg::mul_op(i_cmd.mul_step);
        sel_res = r_res[i_cmd.comp];
        sel_mag = sel_res[W-1] ? (~sel_res + 1'b1) : sel_res;
        mul_a   = i_cmd.mul_sq ? sel_res : r_a[op.a_sel];
        mul_b   = i_cmd.mul_sq ? sel_res : r_b[op.b_sel];
        mul_p   = PW'(mul_a) * PW'(mul_b);
    end

    always_comb begin
        logic signed [AW-1:0] rnd;
        logic signed [AW-1:0] sh;
        for (int i = 0; i < qcr_pkg::NUM_COMP; i++) begin
            rnd = r_acc[i] + HALF;
            sh  = rnd >>> F;
            if (sh > SAT_MAX) begin
                fin[i] = SAT_MAX[W-1:0];
            end else if (sh < SAT_MIN) begin
                fin[i] = SAT_MIN[W-1:0];
            end else begin
                fin[i] = sh[W-1:0];
            end
        end
    end

    always_comb begin
        srem_sh = {r_srem[QW-3:0], r_sqs[SW-1:SW-2]};
        trial   = QW'({r_root, 2'b01});
        dsh     = {r_drem[DW-2:0], r_num[NW-1]};
        qbit    = (dsh >= DW'(r_root));
        q_mag   = r_num[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid <= 1'b0;
        end else begin
            r_pvalid <= i_cmd.mul_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a[0] <= i_a_x;
            r_a[1] <= i_a_y;
            r_a[2] <= i_a_z;
            r_a[3] <= i_a_w;
            r_b[0] <= i_b_x;
            r_b[1] <= i_b_y;
            r_b[2] <= i_b_z;
            r_b[3] <= i_b_w;
        end
        r_prod  <= mul_p;
        r_psq   <= i_cmd.mul_sq;
        r_pneg  <= op.neg;
        r_pcomp <= i_cmd.mul_sq ? i_cmd.comp : i_cmd.mul_step[3:2];

        if (i_cmd.load) begin
            r_sum <= '0;
            for (int i = 0; i < qcr_pkg::NUM_COMP; i++) begin
                r_acc[i] <= '0;
            end
        end else if (r_pvalid) begin
            if (r_psq) begin
                r_sum <= r_sum + SW'(unsigned'(r_prod));
            end else begin
                for (int i = 0; i < qcr_pkg::NUM_COMP; i++) begin
                    if (r_pcomp == 2'(i)) begin
                        r_acc[i] <= r_pneg ? (r_acc[i] - AW'(r_prod))
                                           : (r_acc[i] + AW'(r_prod));
                    end
                end
            end
        end

        if (i_cmd.finish) begin
            for (int i = 0; i < qcr_pkg::NUM_COMP; i++) begin
                r_res[i] <= fin[i];
            end
        end else if (i_cmd.div_store) begin
            r_res[i_cmd.comp] <= r_dneg ? $signed(~q_mag + 1'b1) : $signed(q_mag);
        end

        if (i_cmd.sqrt_init) begin
            r_sqs  <= r_sum;
            r_srem <= '0;
            r_root <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_sqs <= r_sqs << 2;
            if (srem_sh >= trial) begin
                r_srem <= srem_sh - trial;
                r_root <= {r_root[RW-2:0], 1'b1};
            end else begin
                r_srem <= srem_sh;
                r_root <= {r_root[RW-2:0], 1'b0};
            end
        end

        if (i_cmd.div_init) begin
            r_num  <= (NW'(sel_mag) << F) + NW'(r_root >> 1);
            r_drem <= '0;
            r_dneg <= sel_res[W-1];
        end else if (i_cmd.div_step) begin
            r_num  <= {r_num[NW-2:0], qbit};
            r_drem <= qbit ? (dsh - DW'(r_root)) : dsh;
        end

        if (i_cmd.push) begin
            for (int i = 0; i < qcr_pkg::NUM_COMP; i++) begin
                r_out[i] <= r_res[i];
            end
        end
    end

    assign o_sts.sum_zero = (r_sum == '0);
    assign o_r_x = r_out[0];
    assign o_r_y = r_out[1];
    assign o_r_z = r_out[2];
    assign o_r_w = r_out[3];

endmodule

FILE: rtl/qcr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcr_ctrl
// Sequencer for composition and normalisation, the composition counter,
// the interval register and the output transaction flag.
// ----------------------------------------------------------------------------
module qcr_ctrl #(
    parameter int W = qcr_pkg::COMPONENT_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_renormalized,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [qcr_pkg::CFG_WIDTH-1:0]   i_cfg_data,
    output qcr_pkg::t_cmd                   o_cmd,
    input  qcr_pkg::t_sts                   i_sts
);

    localparam int CW = $clog2(2 * W);
    localparam logic [CW-1:0] MUL_LAST  = CW'(qcr_pkg::COMPOSE_STEPS - 1);
    localparam logic [CW-1:0] SQ_LAST   = CW'(qcr_pkg::NUM_COMP - 1);
    localparam logic [CW-1:0] SQRT_LAST = CW'(W);
    localparam logic [CW-1:0] DIV_LAST  = CW'(2 * W - 3);

    qcr_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_cnt;
    logic [1:0]      r_comp;
    logic [qcr_pkg::CFG_WIDTH-1:0] r_interval;
    logic [qcr_pkg::CFG_WIDTH-1:0] r_count;
    logic            r_do_norm;
    logic            r_norm_res;
    logic            r_out_valid;
    logic            r_out_renorm;
    logic            accept;
    logic            slot_free;

    assign accept    = i_in_valid && (r_state == qcr_pkg::ST_IDLE);
    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            qcr_pkg::ST_IDLE:      if (i_in_valid) n_state = qcr_pkg::ST_MUL;
            qcr_pkg::ST_MUL:       if (r_cnt == MUL_LAST) n_state = qcr_pkg::ST_MUL_DRAIN;
            qcr_pkg::ST_MUL_DRAIN: n_state = qcr_pkg::ST_FINISH;
            qcr_pkg::ST_FINISH:    n_state = r_do_norm ? qcr_pkg::ST_SQ : qcr_pkg::ST_DONE;
            qcr_pkg::ST_SQ:        if (r_cnt == SQ_LAST) n_state = qcr_pkg::ST_SQ_DRAIN;
            qcr_pkg::ST_SQ_DRAIN:  n_state = qcr_pkg::ST_SQ_CHECK;
            qcr_pkg::ST_SQ_CHECK:  begin
                n_state = i_sts.sum_zero ? qcr_pkg::ST_DONE : qcr_pkg::ST_SQRT;
            end
            qcr_pkg::ST_SQRT:      if (r_cnt == SQRT_LAST) n_state = qcr_pkg::ST_DIV_INIT;
            qcr_pkg::ST_DIV_INIT:  n_state = qcr_pkg::ST_DIV;
            qcr_pkg::ST_DIV:       if (r_cnt == DIV_LAST) n_state = qcr_pkg::ST_DIV_STORE;
            qcr_pkg::ST_DIV_STORE: begin
                n_state = (r_comp == 2'd3) ? qcr_pkg::ST_DONE : qcr_pkg::ST_DIV_INIT;
            end
            qcr_pkg::ST_DONE:      if (slot_free) n_state = qcr_pkg::ST_IDLE;
            default:               n_state = qcr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.mul_step = r_cnt[3:0];
        o_cmd.comp     = r_comp;
        unique case (r_state)
            qcr_pkg::ST_IDLE:      o_cmd.load = i_in_valid;
            qcr_pkg::ST_MUL:       o_cmd.mul_en = 1'b1;
            qcr_pkg::ST_FINISH:    o_cmd.finish = 1'b1;
            qcr_pkg::ST_SQ:        begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_sq = 1'b1;
                o_cmd.comp   = r_cnt[1:0];
            end
            qcr_pkg::ST_SQ_CHECK:  o_cmd.sqrt_init = 1'b1;
            qcr_pkg::ST_SQRT:      o_cmd.sqrt_step = 1'b1;
            qcr_pkg::ST_DIV_INIT:  o_cmd.div_init = 1'b1;
            qcr_pkg::ST_DIV:       o_cmd.div_step = 1'b1;
            qcr_pkg::ST_DIV_STORE: o_cmd.div_store = 1'b1;
            qcr_pkg::ST_DONE:      o_cmd.push = slot_free;
            default:               o_cmd.load = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= qcr_pkg::ST_IDLE;
            r_cnt        <= '0;
            r_comp       <= '0;
            r_interval   <= qcr_pkg::INTERVAL_RESET;
            r_count      <= '0;
            r_do_norm    <= 1'b0;
            r_norm_res   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_out_renorm <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_interval <= i_cfg_data;
            end
            if (accept) begin
                r_norm_res <= 1'b0;
                if (r_count >= r_interval) begin
                    r_count   <= '0;
                    r_do_norm <= 1'b1;
                end else begin
                    r_count   <= r_count + 1'b1;
                    r_do_norm <= 1'b0;
                end
            end
            if (r_state != n_state) begin
                r_cnt <= '0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (r_state == qcr_pkg::ST_SQ_CHECK) begin
                r_comp <= '0;
            end else if (r_state == qcr_pkg::ST_DIV_STORE) begin
                r_comp     <= r_comp + 1'b1;
                r_norm_res <= 1'b1;
            end
            if (o_cmd.push) begin
                r_out_valid  <= 1'b1;
                r_out_renorm <= r_norm_res;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready     = (r_state == qcr_pkg::ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_renormalized = r_out_renorm;
    assign o_cfg_ready    = 1'b1;

endmodule

FILE: rtl/quaternion_compose_renormalize_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_compose_renormalize_top
// Composes two fixed-point quaternions and periodically scales the result to
// unit length.
// ----------------------------------------------------------------------------
// A plain item's run is set by sixteen products through the single shared
// multiplier. A normalised item also runs the bit-serial square root and the
// divider shared by all components.
// One item at a time; the next is accepted while a result waits at the output.
// Synchronous active-low reset clears the counter and restores the interval.
module quaternion_compose_renormalize_top #(
    parameter int COMPONENT_WIDTH = qcr_pkg::COMPONENT_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [COMPONENT_WIDTH-1:0]   i_a_x,
    input  logic signed [COMPONENT_WIDTH-1:0]   i_a_y,
    input  logic signed [COMPONENT_WIDTH-1:0]   i_a_z,
    input  logic signed [COMPONENT_WIDTH-1:0]   i_a_w,
    input  logic signed [COMPONENT_WIDTH-1:0]   i_b_x,
    input  logic signed [COMPONENT_WIDTH-1:0]   i_b_y,
    input  logic signed [COMPONENT_WIDTH-1:0]   i_b_z,
    input  logic signed [COMPONENT_WIDTH-1:0]   i_b_w,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [COMPONENT_WIDTH-1:0]   o_r_x,
    output logic signed [COMPONENT_WIDTH-1:0]   o_r_y,
    output logic signed [COMPONENT_WIDTH-1:0]   o_r_z,
    output logic signed [COMPONENT_WIDTH-1:0]   o_r_w,
    output logic                                o_renormalized,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [qcr_pkg::CFG_WIDTH-1:0]       i_cfg_data
);

    qcr_pkg::t_cmd cmd;
    qcr_pkg::t_sts sts;

    qcr_ctrl #(.W(COMPONENT_WIDTH)) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_renormalized (o_renormalized),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_cmd          (cmd),
        .i_sts          (sts)
    );

    qcr_datapath #(.W(COMPONENT_WIDTH)) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_a_x   (i_a_x),
        .i_a_y   (i_a_y),
        .i_a_z   (i_a_z),
        .i_a_w   (i_a_w),
        .i_b_x   (i_b_x),
        .i_b_y   (i_b_y),
        .i_b_z   (i_b_z),
        .i_b_w   (i_b_w),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_r_x   (o_r_x),
        .o_r_y   (o_r_y),
        .o_r_z   (o_r_z),
        .o_r_w   (o_r_w)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted again while an item is in progress");

    a_push_into_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.push |-> (!o_out_valid || i_out_ready))
        else $error("result pushed over an untaken output");

    a_single_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.mul_en, cmd.finish, cmd.sqrt_init, cmd.sqrt_step,
                  cmd.div_init, cmd.div_step, cmd.div_store, cmd.push}))
        else $error("more than one datapath command in one cycle");

endmodule
